// File: sv/h2r_pkg.sv
// Shared constants and types for the HSV to RGB converter pipeline.
package h2r_pkg;

    localparam logic [8:0]  HUE_FULL = 9'd360;
    localparam logic [5:0]  SEC_DEG  = 6'd60;
    localparam logic [6:0]  PCT_MAX  = 7'd100;
    // 100 * 60, the full scale of the ramp terms
    localparam logic [12:0] RAMP_MAX = 13'd6000;

    // Sector boundaries in degrees
    localparam logic [8:0] DEG_60  = 9'd60;
    localparam logic [8:0] DEG_120 = 9'd120;
    localparam logic [8:0] DEG_180 = 9'd180;
    localparam logic [8:0] DEG_240 = 9'd240;
    localparam logic [8:0] DEG_300 = 9'd300;

    // Channel scales: 255/100 = 51/20, 255/10000 = 51/2000, 255/600000 = 17/40000
    localparam logic [4:0]  MUL_17 = 5'd17;
    localparam logic [5:0]  MUL_51 = 6'd51;

    // Exact floor division by reciprocal after the power-of-two part is shifted out
    // ramp terms: /64 then /625
    localparam int          RAMP_PRE   = 6;
    localparam logic [17:0] RECIP_625  = 18'd214749;
    localparam int          SHIFT_625  = 27;
    // flat term: /16 then /125
    localparam int          FLAT_PRE   = 4;
    localparam logic [15:0] RECIP_125  = 16'd33555;
    localparam int          SHIFT_125  = 22;
    // peak term: /4 then /5
    localparam int          PEAK_PRE   = 2;
    localparam logic [10:0] RECIP_5    = 11'd1639;
    localparam int          SHIFT_5    = 13;

    // 60-degree hue sectors, named by the channel at peak and the one ramping
    typedef enum logic [2:0] {
        SEC_R_UP_G = 3'd0,
        SEC_G_DN_R = 3'd1,
        SEC_G_UP_B = 3'd2,
        SEC_B_DN_G = 3'd3,
        SEC_B_UP_R = 3'd4,
        SEC_R_DN_B = 3'd5
    } sector_t;

    // Front end result: sector, ramp terms and scaled value
    typedef struct packed {
        logic        valid;
        sector_t     sector;
        logic [6:0]  flat;   // 100 - s
        logic [12:0] down;   // 6000 - s*f
        logic [12:0] up;     // 6000 - s*(60-f)
        logic [10:0] v17;    // 17 * v
        logic [12:0] v51;    // 51 * v
    } h2r_frac_t;

endpackage

// File: sv/h2r_front.sv
// Front end stages: input clamp, sector split, ramp products.
module h2r_front
    import h2r_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [8:0] hue,
    input  logic [6:0] saturation,
    input  logic [6:0] brightness,
    output h2r_frac_t  frac
);

    logic       s1_valid_reg;
    sector_t    s1_sector_reg;
    logic [5:0] s1_f_reg;
    logic [6:0] s1_s_reg;
    logic [6:0] s1_v_reg;

    logic [8:0] h_wrap;
    logic [8:0] base;
    sector_t    sector_next;
    logic [5:0] f_next;
    logic [6:0] s_next;
    logic [6:0] v_next;

    logic [5:0]  f_rest;
    logic [12:0] s_f;
    logic [12:0] s_rest;
    h2r_frac_t   frac_next;
    h2r_frac_t   frac_reg;

    // stage 1: wrap, clamp, sector
    always_comb
    begin
        h_wrap = (hue >= HUE_FULL) ? (hue - HUE_FULL) : hue;
        if (h_wrap < DEG_60)
        begin
            sector_next = SEC_R_UP_G;
            base        = 9'd0;
        end
        else if (h_wrap < DEG_120)
        begin
            sector_next = SEC_G_DN_R;
            base        = DEG_60;
        end
        else if (h_wrap < DEG_180)
        begin
            sector_next = SEC_G_UP_B;
            base        = DEG_120;
        end
        else if (h_wrap < DEG_240)
        begin
            sector_next = SEC_B_DN_G;
            base        = DEG_180;
        end
        else if (h_wrap < DEG_300)
        begin
            sector_next = SEC_B_UP_R;
            base        = DEG_240;
        end
        else
        begin
            sector_next = SEC_R_DN_B;
            base        = DEG_300;
        end
        f_next = 6'(h_wrap - base);
        s_next = (saturation > PCT_MAX) ? PCT_MAX : saturation;
        v_next = (brightness > PCT_MAX) ? PCT_MAX : brightness;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sector_reg <= sector_next;
        s1_f_reg      <= f_next;
        s1_s_reg      <= s_next;
        s1_v_reg      <= v_next;
    end

    // stage 2: ramp terms
    always_comb
    begin
        f_rest = SEC_DEG - s1_f_reg;
        s_f    = 13'(s1_s_reg) * 13'(s1_f_reg);
        s_rest = 13'(s1_s_reg) * 13'(f_rest);

        frac_next.valid  = s1_valid_reg;
        frac_next.sector = s1_sector_reg;
        frac_next.flat   = PCT_MAX - s1_s_reg;
        frac_next.down   = RAMP_MAX - s_f;
        frac_next.up     = RAMP_MAX - s_rest;
        frac_next.v17    = 11'(s1_v_reg) * 11'(MUL_17);
        frac_next.v51    = 13'(s1_v_reg) * 13'(MUL_51);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_reg.valid <= 1'b0;
        end
        else
        begin
            frac_reg <= frac_next;
        end
    end

    assign frac = frac_reg;

endmodule

// File: sv/hsv_to_rgb_converter.sv
// Top level: pipelined HSV to RGB conversion, one item per clock.
//
//  channel | signals                          | handshake
//  --------+----------------------------------+-------------------------------
//  input   | hue, saturation, brightness      | taken when start && !busy
//  result  | red, green, blue                 | done pulses for one cycle
//
//  One item per clock; busy never rises.
//  Five register stages; the last one drives done and the result.
//  Stage depth is set by the 18x18 reciprocal multiply in stage four.
//  Reset clears only the valid bits; nothing is in flight afterwards.
//  The receiver cannot stall, so the pipe never holds.
module hsv_to_rgb_converter
    import h2r_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [8:0] hue,
    input  logic [6:0] saturation,
    input  logic [6:0] brightness,
    output logic       done,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue
);

    h2r_frac_t frac;

    logic [23:0] down_prod;
    logic [23:0] up_prod;
    logic [18:0] flat_prod;

    logic        s3_valid_reg;
    sector_t     s3_sector_reg;
    logic [17:0] s3_down_reg;
    logic [17:0] s3_up_reg;
    logic [14:0] s3_flat_reg;
    logic [10:0] s3_peak_reg;

    logic [35:0] down_q;
    logic [35:0] up_q;
    logic [30:0] flat_q;
    logic [21:0] peak_q;

    logic        s4_valid_reg;
    sector_t     s4_sector_reg;
    logic [7:0]  yc_reg;
    logic [7:0]  zc_reg;
    logic [7:0]  xc_reg;
    logic [7:0]  vc_reg;

    logic [7:0]  red_next;
    logic [7:0]  green_next;
    logic [7:0]  blue_next;
    logic        done_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;

    assign busy = 1'b0;

    h2r_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .frac       (frac)
    );

    // stage 3: scale by value, drop the power-of-two part of the divisor
    assign down_prod = 24'(frac.v17) * 24'(frac.down);
    assign up_prod   = 24'(frac.v17) * 24'(frac.up);
    assign flat_prod = 19'(frac.v51) * 19'(frac.flat);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= frac.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_sector_reg <= frac.sector;
        s3_down_reg   <= down_prod[RAMP_PRE +: 18];
        s3_up_reg     <= up_prod[RAMP_PRE +: 18];
        s3_flat_reg   <= flat_prod[FLAT_PRE +: 15];
        s3_peak_reg   <= frac.v51[PEAK_PRE +: 11];
    end

    // stage 4: exact floor division by the odd part via reciprocal
    assign down_q = 36'(s3_down_reg) * 36'(RECIP_625);
    assign up_q   = 36'(s3_up_reg) * 36'(RECIP_625);
    assign flat_q = 31'(s3_flat_reg) * 31'(RECIP_125);
    assign peak_q = 22'(s3_peak_reg) * 22'(RECIP_5);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_sector_reg <= s3_sector_reg;
        yc_reg        <= down_q[SHIFT_625 +: 8];
        zc_reg        <= up_q[SHIFT_625 +: 8];
        xc_reg        <= flat_q[SHIFT_125 +: 8];
        vc_reg        <= peak_q[SHIFT_5 +: 8];
    end

    // stage 5: route terms to channels
    always_comb
    begin
        case (s4_sector_reg)
            SEC_R_UP_G:
            begin
                red_next = vc_reg; green_next = zc_reg; blue_next = xc_reg;
            end
            SEC_G_DN_R:
            begin
                red_next = yc_reg; green_next = vc_reg; blue_next = xc_reg;
            end
            SEC_G_UP_B:
            begin
                red_next = xc_reg; green_next = vc_reg; blue_next = zc_reg;
            end
            SEC_B_DN_G:
            begin
                red_next = xc_reg; green_next = yc_reg; blue_next = vc_reg;
            end
            SEC_B_UP_R:
            begin
                red_next = zc_reg; green_next = xc_reg; blue_next = vc_reg;
            end
            default:
            begin
                red_next = vc_reg; green_next = xc_reg; blue_next = yc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

    // every item comes out as a done strobe
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##5 done)
        else $error("item lost in pipeline");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 5))
        else $error("result without an item");

    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        (start && saturation == 7'd0) |-> ##5 (red == green && green == blue))
        else $error("zero saturation not grey");

    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        (start && brightness == 7'd100) |-> ##5
        (red == 8'd255 || green == 8'd255 || blue == 8'd255))
        else $error("full value lost its peak channel");

endmodule
